// File: src/bda_pkg.sv
package bda_pkg;

  localparam int unsigned MAX_OUT_WIDTH = 256;
  localparam int unsigned MAX_FACTOR    = 16;
  localparam int unsigned HEIGHT_LIMIT  = 4096;

  localparam int unsigned COL_W   = $clog2(MAX_OUT_WIDTH);
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned AREA_W  = $clog2(MAX_FACTOR * MAX_FACTOR) + 1;
  localparam int unsigned DIVD_W  = SUM_W + 1;
  localparam int unsigned STEP_W  = $clog2(DIVD_W + 1);

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [4:0]  RST_OVERSAMPLING = 5'd4;
  localparam logic [8:0]  RST_OUT_WIDTH    = 9'd256;
  localparam logic [12:0] RST_OUT_HEIGHT   = 13'd16;

  localparam logic [7:0] PIXEL_MAX = 8'hff;

  typedef enum logic [1:0] {
    CFG_OVERSAMPLING = 2'd0,
    CFG_OUT_WIDTH    = 2'd1,
    CFG_OUT_HEIGHT   = 2'd2
  } cfg_idx_e;

  // effective geometry, already clamped
  typedef struct packed {
    logic [4:0]        factor;
    logic [8:0]        width;
    logic [12:0]       height;
    logic [AREA_W-1:0] area;
  } bda_cfg_t;

  // one classified sample travelling from front to back
  typedef struct packed {
    logic [7:0]       sample;
    logic [COL_W-1:0] col;
    logic             first;
    logic             last;
    logic             row_end;
    logic             frame_end;
  } bda_item_t;

  // one finished block sum handed to the divider
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             row_end;
    logic             frame_end;
  } bda_div_req_t;

endpackage

// File: src/bda_front.sv
module bda_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bda_pkg::bda_cfg_t   cfg_i,
  input  logic                in_valid_i,
  input  logic [7:0]          sample_i,
  output bda_pkg::bda_item_t  item_o
);
  import bda_pkg::*;

  logic [3:0]       sub_col_q, sub_col_d;
  logic [3:0]       sub_row_q, sub_row_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic [11:0]      out_row_q, out_row_d;
  logic             last_sc, last_sr, last_oc, last_or;

  assign last_sc = ({1'b0, sub_col_q} + 5'd1) >= cfg_i.factor;
  assign last_sr = ({1'b0, sub_row_q} + 5'd1) >= cfg_i.factor;
  assign last_oc = ({1'b0, out_col_q} + 9'd1) >= cfg_i.width;
  assign last_or = ({1'b0, out_row_q} + 13'd1) >= cfg_i.height;

  always_comb begin
    item_o.sample    = sample_i;
    item_o.col       = out_col_q;
    item_o.first     = (sub_col_q == 4'd0) && (sub_row_q == 4'd0);
    item_o.last      = last_sc && last_sr;
    item_o.row_end   = last_oc;
    item_o.frame_end = last_oc && last_or;
  end

  // advance the raster position: sub column, block column, sub row, block row
  always_comb begin
    sub_col_d = sub_col_q;
    out_col_d = out_col_q;
    sub_row_d = sub_row_q;
    out_row_d = out_row_q;
    if (in_valid_i) begin
      if (!last_sc) begin
        sub_col_d = sub_col_q + 4'd1;
      end else begin
        sub_col_d = '0;
        if (!last_oc) begin
          out_col_d = out_col_q + COL_W'(1);
        end else begin
          out_col_d = '0;
          if (!last_sr) begin
            sub_row_d = sub_row_q + 4'd1;
          end else begin
            sub_row_d = '0;
            out_row_d = last_or ? 12'd0 : out_row_q + 12'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_col_q <= '0;
      out_col_q <= '0;
      sub_row_q <= '0;
      out_row_q <= '0;
    end else begin
      sub_col_q <= sub_col_d;
      out_col_q <= out_col_d;
      sub_row_q <= sub_row_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

// File: src/bda_fifo.sv
module bda_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  bda_pkg::bda_item_t  wdata_i,
  output logic                full_o,
  input  logic                rd_i,
  output bda_pkg::bda_item_t  rdata_o,
  output logic                empty_o
);
  import bda_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  bda_item_t        store_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = store_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd) count_d = count_q + CNT_W'(1);
    else if (do_rd && !do_wr) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) store_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= PTR_W'((32'(wr_ptr_q) + 1) % QUEUE_DEPTH);
      if (do_rd) rd_ptr_q <= PTR_W'((32'(rd_ptr_q) + 1) % QUEUE_DEPTH);
      count_q <= count_d;
    end
  end

endmodule

// File: src/bda_back.sv
module bda_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  bda_pkg::bda_item_t    q_item_i,
  output logic                  q_pop_o,
  output logic                  req_valid_o,
  output bda_pkg::bda_div_req_t req_o,
  input  logic                  req_ready_i
);
  import bda_pkg::*;

  logic [SUM_W-1:0] acc_mem_q [MAX_OUT_WIDTH];
  logic [SUM_W-1:0] rd_q;
  bda_item_t        b_item_q;
  logic             b_valid_q;
  logic             b_fwd_q;
  logic [SUM_W-1:0] b_fwd_sum_q;
  logic [SUM_W-1:0] acc, b_sum;
  logic             b_adv;

  // take the bypass when the previous item wrote the same column on the read edge
  assign acc   = b_fwd_q ? b_fwd_sum_q : rd_q;
  assign b_sum = b_item_q.first ? {8'd0, b_item_q.sample}
                                : acc + {8'd0, b_item_q.sample};

  assign b_adv   = b_valid_q && (!b_item_q.last || req_ready_i);
  assign q_pop_o = !q_empty_i && (!b_valid_q || b_adv);

  assign req_valid_o     = b_valid_q && b_item_q.last;
  assign req_o.sum       = b_sum;
  assign req_o.row_end   = b_item_q.row_end;
  assign req_o.frame_end = b_item_q.frame_end;

  always_ff @(posedge clk_i) begin
    if (b_adv) acc_mem_q[b_item_q.col] <= b_sum;
    if (q_pop_o) begin
      rd_q        <= acc_mem_q[q_item_i.col];
      b_item_q    <= q_item_i;
      b_fwd_q     <= b_adv && (b_item_q.col == q_item_i.col);
      b_fwd_sum_q <= b_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      b_valid_q <= 1'b1;
    end else if (b_adv) begin
      b_valid_q <= 1'b0;
    end
  end

endmodule

// File: src/bda_div.sv
module bda_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [bda_pkg::AREA_W-1:0] area_i,
  input  logic                  req_valid_i,
  input  bda_pkg::bda_div_req_t req_i,
  output logic                  req_ready_o,
  input  logic                  pop,
  output logic                  empty,
  output logic [7:0]            pixel_o,
  output logic                  row_end_o,
  output logic                  frame_end_o
);
  import bda_pkg::*;

  localparam int unsigned REM_W = AREA_W;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic              re_q, re_d, fe_q, fe_d;
  logic [REM_W:0]    shifted;
  logic              done, push, load;
  logic [7:0]        result;

  logic [7:0]        oq_pix_q [2];
  logic              oq_re_q  [2];
  logic              oq_fe_q  [2];
  logic              oq_wr_q, oq_rd_q;
  logic [1:0]        oq_cnt_q;
  logic              oq_pop;

  assign done        = busy_q && (cnt_q == '0);
  assign push        = done && (oq_cnt_q != 2'd2);
  assign req_ready_o = !busy_q || push;
  assign load        = req_valid_i && req_ready_o;
  assign result      = (|quo_q[DIVD_W-1:8]) ? PIXEL_MAX : quo_q[7:0];
  assign shifted     = {rem_q, quo_q[DIVD_W-1]};

  // restoring division, one quotient bit a cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    re_d   = re_q;
    fe_d   = fe_q;
    if (load) begin
      busy_d = 1'b1;
      rem_d  = '0;
      quo_d  = {1'b0, req_i.sum} + DIVD_W'(area_i >> 1);
      cnt_d  = (area_i == AREA_W'(1)) ? '0 : STEP_W'(DIVD_W);
      re_d   = req_i.row_end;
      fe_d   = req_i.frame_end;
    end else if (busy_q && cnt_q != '0) begin
      cnt_d = cnt_q - STEP_W'(1);
      if (shifted >= {1'b0, area_i}) begin
        rem_d = REM_W'(shifted - {1'b0, area_i});
        quo_d = {quo_q[DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[REM_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b0};
      end
    end else if (push) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    re_q  <= re_d;
    fe_q  <= fe_d;
    if (push) begin
      oq_pix_q[oq_wr_q] <= result;
      oq_re_q[oq_wr_q]  <= re_q;
      oq_fe_q[oq_wr_q]  <= fe_q;
    end
  end

  assign empty       = oq_cnt_q == 2'd0;
  assign oq_pop      = pop && !empty;
  assign pixel_o     = oq_pix_q[oq_rd_q];
  assign row_end_o   = oq_re_q[oq_rd_q];
  assign frame_end_o = oq_fe_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      if (push) oq_wr_q <= !oq_wr_q;
      if (oq_pop) oq_rd_q <= !oq_rd_q;
      if (push && !oq_pop) oq_cnt_q <= oq_cnt_q + 2'd1;
      else if (oq_pop && !push) oq_cnt_q <= oq_cnt_q - 2'd1;
    end
  end

endmodule

// File: src/box_downsample_average.sv
// Path: a block's last sample passes the sample queue, the back stage and the divider
//   into the result queue; the divider makes one quotient bit a cycle if factor > 1.
// Throughput: one sample a cycle into the accumulators unless the queue is full; the
//   shared divider holds one sum; factor 1 gives one pixel a cycle while not stalled.
// Reset: rst_ni is asynchronous, active low; it clears the raster counters, the queues
//   and the registers to factor 4, width 256, height 16. Accumulators are not reset.
module box_downsample_average (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample input, queue style
  input  logic        push,
  output logic        full,
  input  logic [7:0]  sample_i,
  // pixel output, queue style
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  pixel_o,
  output logic        row_end_o,
  output logic        frame_end_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  import bda_pkg::*;

  logic [4:0]   oversampling_q;
  logic [8:0]   out_width_q;
  logic [12:0]  out_height_q;
  bda_cfg_t     cfg;
  logic [4:0]   factor;
  logic         in_accept;
  bda_item_t    front_item, back_item;
  logic         q_empty, q_pop;
  logic         req_valid, req_ready;
  bda_div_req_t req;

  // Always writable; the user keeps the block idle when registers change (unenforced).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oversampling_q <= RST_OVERSAMPLING;
      out_width_q    <= RST_OUT_WIDTH;
      out_height_q   <= RST_OUT_HEIGHT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OVERSAMPLING: oversampling_q <= cfg_data_i[4:0];
        CFG_OUT_WIDTH:    out_width_q    <= cfg_data_i[8:0];
        CFG_OUT_HEIGHT:   out_height_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the geometry: factors below 2 act as 1, zero sizes as 1, oversize saturates.
  always_comb begin
    if (oversampling_q < 5'd2) factor = 5'd1;
    else if (oversampling_q > 5'(MAX_FACTOR)) factor = 5'(MAX_FACTOR);
    else factor = oversampling_q;

    cfg.factor = factor;
    cfg.area   = AREA_W'(factor) * AREA_W'(factor);

    if (out_width_q == '0) cfg.width = 9'd1;
    else if (out_width_q > 9'(MAX_OUT_WIDTH)) cfg.width = 9'(MAX_OUT_WIDTH);
    else cfg.width = out_width_q;

    if (out_height_q == '0) cfg.height = 13'd1;
    else if (out_height_q > 13'(HEIGHT_LIMIT)) cfg.height = 13'(HEIGHT_LIMIT);
    else cfg.height = out_height_q;
  end

  assign in_accept = push && !full;

  // Front: track the raster position and tag each sample.
  bda_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_accept),
    .sample_i   (sample_i),
    .item_o     (front_item)
  );

  // Short queue: lets the front keep taking samples while the back waits on the divider.
  bda_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (in_accept),
    .wdata_i (front_item),
    .full_o  (full),
    .rd_i    (q_pop),
    .rdata_o (back_item),
    .empty_o (q_empty)
  );

  // Back: read, add and write the column accumulator; hand finished sums on.
  bda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (back_item),
    .q_pop_o     (q_pop),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  // Rounded average and the result queue.
  bda_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .area_i      (cfg.area),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ready_o (req_ready),
    .pop         (pop),
    .empty       (empty),
    .pixel_o     (pixel_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bda_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 8;
  // Covers the divider's work on a sum; leave a comfortable margin on top
  localparam int SETTLE_CYCLES = 40;
  localparam int TIMEOUT_NS    = 3_000_000;
  localparam int ITEM_GOAL     = 25;
  localparam int PIXEL_GOAL    = 5;
  localparam int HOLD_OFF_LEN  = 300;
  // Index beyond the register list; a write there must change nothing
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] value;
    logic       row_end;
    logic       frame_end;
  } pixel_word_t;

  // ---------------------------------------------------------------------------
  // DUT connections; every input holds a known value from time zero
  // ---------------------------------------------------------------------------
  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic [7:0]  sample    = '0;
  logic        pop       = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data  = '0;
  logic        full;
  logic        empty;
  logic        cfg_ready;
  logic [7:0]  pixel;
  logic        row_end;
  logic        frame_end;

  box_downsample_average u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .sample_i    (sample),
    .empty       (empty),
    .pop         (pop),
    .pixel_o     (pixel),
    .row_end_o   (row_end),
    .frame_end_o (frame_end),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shared run state
  // ---------------------------------------------------------------------------
  int gap_pct          = 0;   // chance in a hundred that the sender idles a cycle
  int stall_pct        = 0;   // chance in a hundred that the receiver stalls a cycle
  int hold_off_request = 0;   // long receiver stall, picked up by the pop process
  int error_count      = 0;
  int items_sent       = 0;
  int pixels_checked   = 0;

  pixel_word_t expected_pixels[$];
  pixel_word_t oldest_pixel;

  // ---------------------------------------------------------------------------
  // Predictor: register copies, block accumulators and raster position
  // ---------------------------------------------------------------------------
  logic [4:0]  reg_factor = RST_OVERSAMPLING;
  logic [8:0]  reg_width  = RST_OUT_WIDTH;
  logic [12:0] reg_height = RST_OUT_HEIGHT;

  logic [SUM_W-1:0] acc_sum [MAX_OUT_WIDTH] = '{default: '0};
  int x_in_block = 0;   // sample column inside the current block
  int y_in_block = 0;   // sample row inside the current block
  int x_block    = 0;   // output column
  int y_block    = 0;   // output row

  // Clamp the raw register values to the geometry the block really uses
  function automatic void effective_geometry(output int n, output int w, output int h);
    n = (reg_factor < 2) ? 1 : (reg_factor > MAX_FACTOR) ? MAX_FACTOR : reg_factor;
    w = (reg_width == 0) ? 1 : (reg_width > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : reg_width;
    h = (reg_height == 0) ? 1 : (reg_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : reg_height;
  endfunction

  // Accumulate one sample and work out the pixel it completes, if any
  function automatic void predict_box_average(input logic [7:0] s, output bit has_pixel,
                                              output pixel_word_t px);
    int n, w, h, col, area, avg;
    bit end_x, end_y, end_col, end_row;
    logic [SUM_W-1:0] sum;
    effective_geometry(n, w, h);
    // A counter left beyond a new, smaller limit counts as the last position
    end_x   = (x_in_block + 1 >= n);
    end_y   = (y_in_block + 1 >= n);
    end_col = (x_block + 1 >= w);
    end_row = (y_block + 1 >= h);
    col = (x_block < MAX_OUT_WIDTH) ? x_block : MAX_OUT_WIDTH - 1;

    // The top-left sample of a block starts a fresh sum; the rest wrap at 16 bits
    if (x_in_block == 0 && y_in_block == 0) sum = SUM_W'(s);
    else sum = acc_sum[col] + SUM_W'(s);
    acc_sum[col] = sum;

    has_pixel = end_x && end_y;
    px = '0;
    if (has_pixel) begin
      area = n * n;
      avg  = (int'(sum) + area / 2) / area;
      // A factor cut mid-block leaves an oversized sum; clip the average
      px.value     = (avg > int'(PIXEL_MAX)) ? PIXEL_MAX : avg[7:0];
      px.row_end   = end_col;
      px.frame_end = end_col && end_row;
    end

    // Advance in raster order of the oversampled canvas
    if (!end_x) begin
      x_in_block++;
    end else begin
      x_in_block = 0;
      if (!end_col) begin
        x_block++;
      end else begin
        x_block = 0;
        if (!end_y) begin
          y_in_block++;
        end else begin
          y_in_block = 0;
          y_block = end_row ? 0 : y_block + 1;
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random pop, with an occasional long hold-off counted here
  // ---------------------------------------------------------------------------
  int hold_off_left = 0;

  always @(posedge clk_i) begin
    if (hold_off_request != 0) begin
      hold_off_left = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: compare every accepted pixel transaction with the oldest
  // expectation, field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got %0d", $time, pixel);
        error_count++;
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        if (pixel !== oldest_pixel.value) begin
          $display("%0t: pixel mismatch, expected %0d, got %0d",
                   $time, oldest_pixel.value, pixel);
          error_count++;
        end
        if (row_end !== oldest_pixel.row_end) begin
          $display("%0t: row_end mismatch, expected %0b, got %0b",
                   $time, oldest_pixel.row_end, row_end);
          error_count++;
        end
        if (frame_end !== oldest_pixel.frame_end) begin
          $display("%0t: frame_end mismatch, expected %0b, got %0b",
                   $time, oldest_pixel.frame_end, frame_end);
          error_count++;
        end
      end
      pixels_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Write one register and mirror it into the predictor on acceptance.
  // Drop valid and wait for the next clock edge so that a following write starts cleanly.
  task automatic write_register(input logic [1:0] index, input logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (index)
      CFG_OVERSAMPLING: reg_factor = data[4:0];
      CFG_OUT_WIDTH:    reg_width  = data[8:0];
      CFG_OUT_HEIGHT:   reg_height = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one sample; push stays high after acceptance so that back-to-back
  // transactions run at full rate
  task automatic send_sample(input logic [7:0] value);
    bit has_pixel;
    pixel_word_t px;
    while ($urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    sample <= value;
    do @(posedge clk_i); while (full);
    predict_box_average(value, has_pixel, px);
    if (has_pixel) expected_pixels.push_back(px);
    items_sent++;
  endtask

  // Stop offering, wait for every expected pixel, then let the block settle
  // so that register writes find it idle
  task automatic finish_batch();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Lean towards the extremes now and then
  function automatic logic [7:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Factor and height left at their reset values; one column of 4x4 blocks,
  // sixteen rows down, so the last pixel must close the frame
  task automatic test_reset_values();
    int i;
    write_register(CFG_OUT_WIDTH, 13'd1);
    for (i = 0; i < 16 * 16; i++) begin
      if (i < 16) send_sample(8'hff);
      else if (i < 32) send_sample(8'h00);
      else send_sample(random_sample());
    end
    finish_batch();
  endtask

  // Pass-through on part of a full-width row, set up via masked register writes;
  // it also writes the accumulators that the small geometries use
  task automatic test_full_row();
    int i;
    write_register(CFG_OVERSAMPLING, 13'h1fe1);   // upper bits are ignored
    write_register(CFG_OUT_HEIGHT, 13'd1);
    write_register(CFG_OUT_WIDTH, 13'h1f08);      // 264 under the mask, clamped to 256
    write_register(CFG_UNUSED, 13'h1fff);         // must leave all registers alone
    for (i = 0; i < 8; i++) begin
      if (i == 0) send_sample(8'h00);
      else if (i == 1) send_sample(8'hff);
      else send_sample((i % 2 == 0) ? 8'h55 : 8'haa);
    end
    finish_batch();
  endtask

  // Zero and oversized geometry: zeros act as one, large values saturate
  task automatic test_clamped_geometry();
    int i;
    write_register(CFG_OVERSAMPLING, 13'd0);
    write_register(CFG_OUT_WIDTH, 13'd0);
    write_register(CFG_OUT_HEIGHT, 13'd0);
    send_sample(8'h00);
    send_sample(8'hff);
    finish_batch();

    // Widest row; this writes every accumulator, so later mid-frame changes
    // never read an unwritten one
    write_register(CFG_OVERSAMPLING, 13'd1);
    write_register(CFG_OUT_WIDTH, 13'h1ff);
    write_register(CFG_OUT_HEIGHT, 13'd1);
    for (i = 0; i < MAX_OUT_WIDTH; i++) send_sample(random_sample());
    finish_batch();

    // Height saturates at the limit, so the frame runs on past the first rows
    write_register(CFG_OUT_WIDTH, 13'd1);
    write_register(CFG_OUT_HEIGHT, 13'h1fff);
    for (i = 0; i < 16; i++) send_sample(random_sample());
    finish_batch();
  endtask

  // Fill a block at the saturated factor of 16, then cut it to factor 2 on
  // its very last sample, so the average far exceeds full scale and must clip
  task automatic test_average_saturation();
    int i;
    write_register(CFG_OVERSAMPLING, 13'd31);
    write_register(CFG_OUT_HEIGHT, 13'd1);
    for (i = 0; i < MAX_FACTOR * MAX_FACTOR - 1; i++) send_sample(8'hff);
    finish_batch();
    write_register(CFG_OVERSAMPLING, 13'd2);
    send_sample(8'hff);
    finish_batch();
  endtask

  // Shrink the geometry while counters sit past the new limits
  task automatic test_mid_frame_change();
    int i;
    write_register(CFG_OVERSAMPLING, 13'd3);
    write_register(CFG_OUT_WIDTH, 13'd4);
    write_register(CFG_OUT_HEIGHT, 13'd2);
    for (i = 0; i < 7; i++) send_sample(random_sample());
    finish_batch();
    write_register(CFG_OUT_WIDTH, 13'd2);
    write_register(CFG_OVERSAMPLING, 13'd2);
    for (i = 0; i < 12; i++) send_sample(random_sample());
    finish_batch();
    write_register(CFG_OUT_HEIGHT, 13'd1);
    for (i = 0; i < 8; i++) send_sample(random_sample());
    finish_batch();
  endtask

  // Hold the receiver off for a long stretch while samples keep coming, so
  // the result queue fills and the input stalls
  task automatic test_back_pressure();
    int i;
    gap_pct   = 0;
    stall_pct = 0;
    write_register(CFG_OVERSAMPLING, 13'd1);
    write_register(CFG_OUT_WIDTH, 13'd8);
    write_register(CFG_OUT_HEIGHT, 13'd4);
    hold_off_request = HOLD_OFF_LEN;
    for (i = 0; i < 48; i++) send_sample(random_sample());
    finish_batch();
  endtask

  // Mostly whole frames of random small geometry; now and then a large
  // factor on a single block, or a frame broken off part way
  task automatic test_random_frames(input int gap, input int stall);
    int start_items, start_pixels, n, w, h, total, stop_at, i;
    int fac, wid, hgt;
    logic [12:0] data;
    gap_pct      = gap;
    stall_pct    = stall;
    start_items  = items_sent;
    start_pixels = pixels_checked;
    while (items_sent - start_items < ITEM_GOAL ||
           pixels_checked - start_pixels < PIXEL_GOAL) begin
      if ($urandom_range(0, 11) == 0) begin
        fac = $urandom_range(5, 31);
        wid = $urandom_range(0, 1);
        hgt = $urandom_range(0, 1);
      end else begin
        fac = $urandom_range(0, 4);
        wid = $urandom_range(0, 8);
        hgt = $urandom_range(0, 3);
      end
      data = 13'($urandom);
      data[4:0] = 5'(fac);
      write_register(CFG_OVERSAMPLING, data);
      // Keep the old width or height at times; both stay small here
      if (fac > 4 || $urandom_range(0, 3) != 0) begin
        data = 13'($urandom);
        data[8:0] = 9'(wid);
        write_register(CFG_OUT_WIDTH, data);
      end
      if (fac > 4 || $urandom_range(0, 3) != 0) begin
        write_register(CFG_OUT_HEIGHT, 13'(hgt));
      end
      effective_geometry(n, w, h);
      total   = n * n * w * h;
      stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total) : total;
      for (i = 0; i < stop_at; i++) send_sample(random_sample());
      finish_batch();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_full_row();
    test_clamped_geometry();
    test_average_saturation();
    test_mid_frame_change();
    test_back_pressure();
    test_random_frames(0, 0);
    test_random_frames(66, 0);
    test_random_frames(0, 66);
    test_random_frames(16, 16);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
